>>> design/sha1_pkg.sv
`timescale 1ns / 1ps

package sha1_pkg;

    // Block and digest geometry
    localparam int ROUNDS        = 80;
    localparam int ROUND_W       = $clog2(ROUNDS);
    localparam int WIN_WORDS     = 16;
    localparam int DIGEST_WORDS  = 5;
    localparam int MSG_LEN_W     = 61;

    // Command codes on the input tuser field
    localparam logic [1:0] CMD_ABSORB        = 2'd0;
    localparam logic [1:0] CMD_ABSORB_FINISH = 2'd1;
    localparam logic [1:0] CMD_FINISH        = 2'd2;

    // Padding marker byte
    localparam logic [7:0] PAD_MARKER = 8'h80;

    // Fill positions that steer the padding sequence
    localparam logic [5:0] FILL_LAST    = 6'd63;
    localparam logic [5:0] FILL_LEN_POS = 6'd56;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_OUT
    } sha1_state_t;

    // Control from the sequencer to the schedule window and round unit
    typedef struct packed {
        logic       load_byte;
        logic [7:0] byte_val;
        logic       round_start;
        logic       round_step;
        logic       chain_add;
        logic       chain_init;
    } sha1_ctrl_t;

    function automatic logic [31:0] init_word(input logic [2:0] idx);
        logic [31:0] w;
        case (idx)
            3'd0:    w = 32'h67452301;
            3'd1:    w = 32'hEFCDAB89;
            3'd2:    w = 32'h98BADCFE;
            3'd3:    w = 32'h10325476;
            default: w = 32'hC3D2E1F0;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] round_k(input logic [ROUND_W-1:0] t);
        logic [31:0] k;
        if (t < ROUND_W'(20)) begin
            k = 32'h5A827999;
        end
        else if (t < ROUND_W'(40)) begin
            k = 32'h6ED9EBA1;
        end
        else if (t < ROUND_W'(60)) begin
            k = 32'h8F1BBCDC;
        end
        else begin
            k = 32'hCA62C1D6;
        end
        return k;
    endfunction

endpackage

>>> design/sha1_sched.sv
`timescale 1ns / 1ps

module sha1_sched (
    input  logic                clk,
    input  sha1_pkg::sha1_ctrl_t ctrl,
    output logic [31:0]         w_cur
);
    import sha1_pkg::*;

    logic [31:0] win_reg  [WIN_WORDS];
    logic [31:0] win_next [WIN_WORDS];
    logic [31:0] w_mix;
    logic [31:0] w_new;

    // Word used by the current round is always the oldest in the window
    assign w_cur = win_reg[0];

    // Next expanded word, sixteen rounds ahead
    assign w_mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign w_new = {w_mix[30:0], w_mix[31]};

    // Shift in message bytes while filling, shift whole words while hashing
    always_comb
    begin
        for (int i = 0; i < WIN_WORDS; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (ctrl.load_byte)
        begin
            for (int i = 0; i < WIN_WORDS - 1; i++)
            begin
                win_next[i] = {win_reg[i][23:0], win_reg[i+1][31:24]};
            end
            win_next[WIN_WORDS-1] = {win_reg[WIN_WORDS-1][23:0], ctrl.byte_val};
        end
        else if (ctrl.round_step)
        begin
            for (int i = 0; i < WIN_WORDS - 1; i++)
            begin
                win_next[i] = win_reg[i+1];
            end
            win_next[WIN_WORDS-1] = w_new;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WIN_WORDS; i++)
        begin
            win_reg[i] <= win_next[i];
        end
    end

endmodule

>>> design/sha1_round.sv
`timescale 1ns / 1ps

module sha1_round (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  sha1_pkg::sha1_ctrl_t                   ctrl,
    input  logic [31:0]                            w_cur,
    output logic [sha1_pkg::DIGEST_WORDS-1:0][31:0] chain_words,
    output logic                                   last_round
);
    import sha1_pkg::*;

    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next;
    logic [ROUND_W-1:0] t_reg, t_next;
    logic [DIGEST_WORDS-1:0][31:0] chain_reg, chain_next;
    logic [31:0] f_val;
    logic [31:0] sum_val;

    assign chain_words = chain_reg;
    assign last_round  = (t_reg == ROUND_W'(ROUNDS - 1));

    // Round function by stage of the compression
    always_comb
    begin
        if (t_reg < ROUND_W'(20))
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
        end
        else if (t_reg < ROUND_W'(40))
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
        end
        else if (t_reg < ROUND_W'(60))
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
        end
    end

    assign sum_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + round_k(t_reg) + w_cur;

    // Load working words, or advance one round
    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        e_next = e_reg;
        t_next = t_reg;
        if (ctrl.round_start)
        begin
            a_next = chain_reg[0];
            b_next = chain_reg[1];
            c_next = chain_reg[2];
            d_next = chain_reg[3];
            e_next = chain_reg[4];
            t_next = '0;
        end
        else if (ctrl.round_step)
        begin
            a_next = sum_val;
            b_next = a_reg;
            c_next = {b_reg[1:0], b_reg[31:2]};
            d_next = c_reg;
            e_next = d_reg;
            t_next = t_reg + ROUND_W'(1);
        end
    end

    // Fold the block result into the chaining words, or restart them
    always_comb
    begin
        chain_next = chain_reg;
        if (ctrl.chain_init)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                chain_next[i] = init_word(3'(i));
            end
        end
        else if (ctrl.chain_add)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
            chain_next[4] = chain_reg[4] + e_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg <= '0;
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                chain_reg[i] <= init_word(3'(i));
            end
        end
        else
        begin
            t_reg     <= t_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
    end

endmodule

>>> design/sha1_hash_engine.sv
`timescale 1ns / 1ps
// Channel   Dir  tdata               tuser              tlast
// s_*       in   [7:0] data_byte     [1:0] cmd          -
// m_*       out  [31:0] digest_word  [2:0] word_index   last_word
//
// Bytes are taken one a cycle in idle; the 64th byte of a block starts the 80
// rounds and the chaining add, all through the single round unit. A finish
// pushes 9 to 72 padding and length bytes, one a cycle, with one idle state
// (ST_PAD_ZERO) before the length; a full block on the way is hashed first. The
// five digest words are then offered one a cycle; m_tready stalls hold the
// output phase. s_tready is high only in idle. Reset loads the initial words.

module sha1_hash_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast
);
    import sha1_pkg::*;

    sha1_state_t state_reg, state_next;
    sha1_state_t resume_reg, resume_next;
    logic [5:0]            fill_reg, fill_next;
    logic [MSG_LEN_W-1:0]  msg_reg, msg_next;
    logic [2:0]            idx_reg, idx_next;
    sha1_ctrl_t            ctrl;
    logic [31:0]           w_cur;
    logic [DIGEST_WORDS-1:0][31:0] chain_words;
    logic                  last_round;
    logic                  s_acc;
    logic                  m_acc;
    logic                  absorb_cmd;
    logic                  block_full;
    logic [63:0]           len_shift;

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = (state_reg == ST_OUT);
    assign s_acc      = s_tvalid & s_tready;
    assign m_acc      = m_tvalid & m_tready;
    assign absorb_cmd = (s_tuser == CMD_ABSORB) || (s_tuser == CMD_ABSORB_FINISH);
    assign block_full = (fill_reg == FILL_LAST);

    // Bit count, most significant byte first as the fill position advances
    assign len_shift = {msg_reg, 3'b000} << {fill_reg[2:0], 3'b000};

    assign m_tdata = chain_words[idx_reg];
    assign m_tuser = idx_reg;
    assign m_tlast = (idx_reg == 3'(DIGEST_WORDS - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    if (absorb_cmd && block_full)
                    begin
                        state_next = ST_ROUND;
                    end
                    else if ((s_tuser == CMD_ABSORB_FINISH) || (s_tuser == CMD_FINISH))
                    begin
                        state_next = ST_PAD_MARK;
                    end
                end
            end
            ST_ROUND:
            begin
                if (last_round)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                state_next = resume_reg;
            end
            ST_PAD_MARK:
            begin
                state_next = block_full ? ST_ROUND : ST_PAD_ZERO;
            end
            ST_PAD_ZERO:
            begin
                if (fill_reg == FILL_LEN_POS)
                begin
                    state_next = ST_PAD_LEN;
                end
                else if (block_full)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_PAD_LEN:
            begin
                if (block_full)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_OUT:
            begin
                if (m_acc && m_tlast)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs and counters
    always_comb
    begin
        ctrl        = '0;
        fill_next   = fill_reg;
        msg_next    = msg_reg;
        idx_next    = idx_reg;
        resume_next = resume_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc && absorb_cmd)
                begin
                    ctrl.load_byte = 1'b1;
                    ctrl.byte_val  = s_tdata;
                    fill_next      = fill_reg + 6'd1;
                    msg_next       = msg_reg + MSG_LEN_W'(1);
                    if (block_full)
                    begin
                        ctrl.round_start = 1'b1;
                        resume_next = (s_tuser == CMD_ABSORB_FINISH) ? ST_PAD_MARK : ST_IDLE;
                    end
                end
            end
            ST_ROUND:
            begin
                ctrl.round_step = 1'b1;
            end
            ST_ADD:
            begin
                ctrl.chain_add = 1'b1;
            end
            ST_PAD_MARK:
            begin
                ctrl.load_byte = 1'b1;
                ctrl.byte_val  = PAD_MARKER;
                fill_next      = fill_reg + 6'd1;
                if (block_full)
                begin
                    ctrl.round_start = 1'b1;
                    resume_next      = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO:
            begin
                if (fill_reg != FILL_LEN_POS)
                begin
                    ctrl.load_byte = 1'b1;
                    ctrl.byte_val  = 8'h00;
                    fill_next      = fill_reg + 6'd1;
                    if (block_full)
                    begin
                        ctrl.round_start = 1'b1;
                        resume_next      = ST_PAD_ZERO;
                    end
                end
            end
            ST_PAD_LEN:
            begin
                ctrl.load_byte = 1'b1;
                ctrl.byte_val  = len_shift[63:56];
                fill_next      = fill_reg + 6'd1;
                if (block_full)
                begin
                    ctrl.round_start = 1'b1;
                    resume_next      = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_acc)
                begin
                    if (m_tlast)
                    begin
                        idx_next        = '0;
                        msg_next        = '0;
                        ctrl.chain_init = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            resume_reg <= ST_IDLE;
            fill_reg   <= '0;
            msg_reg    <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            resume_reg <= resume_next;
            fill_reg   <= fill_next;
            msg_reg    <= msg_next;
            idx_reg    <= idx_next;
        end
    end

    sha1_sched u_sched (
        .clk   (clk),
        .ctrl  (ctrl),
        .w_cur (w_cur)
    );

    sha1_round u_round (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .w_cur       (w_cur),
        .chain_words (chain_words),
        .last_round  (last_round)
    );

endmodule
